@@ sv/lccs_pkg.sv @@
// ----------------------------------------------------------------------------
// lccs_pkg
// shared types, codes and sizes for the least cost capacity server selector
// ----------------------------------------------------------------------------
package lccs_pkg;

  localparam int SERVERS     = 16;
  localparam int COST_BITS   = 16;
  localparam int LOAD_BITS   = 16;
  localparam int IDX_W       = $clog2(SERVERS);
  localparam int COUNT_W     = $clog2(SERVERS + 1);
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COST_BITS-1:0] NO_LINK  = {COST_BITS{1'b1}};
  localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

  // command codes on the input field
  localparam logic [1:0] CMD_DISTRIBUTE = 2'd0;
  localparam logic [1:0] CMD_COMPLETE   = 2'd1;
  localparam logic [1:0] CMD_WRITE      = 2'd2;

  // status codes on the result field
  localparam logic [2:0] ST_ASSIGNED  = 3'd0;
  localparam logic [2:0] ST_NONE      = 3'd1;
  localparam logic [2:0] ST_COMPLETED = 3'd2;
  localparam logic [2:0] ST_COMP_ERR  = 3'd3;
  localparam logic [2:0] ST_WRITTEN   = 3'd4;

  // configuration register indexes
  localparam logic REG_SERVERS_IN_USE = 1'b0;
  localparam logic REG_LOAD_LIMIT     = 1'b1;

  typedef enum logic [1:0] {
    OP_DISTRIBUTE,
    OP_COMPLETE,
    OP_WRITE
  } op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  server;
    logic [3:0]  target;
    logic [15:0] cost;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  chosen;
    logic [15:0] load;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [LOAD_BITS-1:0] load_limit;
  } cfg_t;

  typedef struct packed {
    op_t                  op;
    logic                 in_range;
    logic [IDX_W-1:0]     server;
    logic [IDX_W-1:0]     target;
    logic [COST_BITS-1:0] cost;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ sv/lccs_front.sv @@
// ----------------------------------------------------------------------------
// lccs_front
// accepts command transactions and turns them into jobs for the queue
// ----------------------------------------------------------------------------
module lccs_front (
  input  logic                     start,
  input  lccs_pkg::in_item_t       request,
  input  lccs_pkg::cfg_t           cfg,
  input  lccs_pkg::queue_status_t  qs,
  output logic                     busy,
  output logic                     push,
  output lccs_pkg::job_t           job
);

  logic accept;
  logic valid_cmd;

  assign busy   = qs.full;
  assign accept = start && !qs.full;

  always_comb begin
    valid_cmd    = 1'b1;
    job.op       = lccs_pkg::OP_DISTRIBUTE;
    job.in_range = ({1'b0, request.server} < cfg.count);
    job.server   = request.server;
    job.target   = request.target;
    job.cost     = request.cost;
    case (request.command)
      lccs_pkg::CMD_DISTRIBUTE: job.op = lccs_pkg::OP_DISTRIBUTE;
      lccs_pkg::CMD_COMPLETE:   job.op = lccs_pkg::OP_COMPLETE;
      lccs_pkg::CMD_WRITE:      job.op = lccs_pkg::OP_WRITE;
      default: begin
        // unused code: taken and dropped
        valid_cmd = 1'b0;
      end
    endcase
  end

  assign push = accept && valid_cmd;

endmodule

@@ sv/lccs_queue.sv @@
// ----------------------------------------------------------------------------
// lccs_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module lccs_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  lccs_pkg::job_t           push_job,
  input  logic                     pop,
  output lccs_pkg::job_t           head,
  output lccs_pkg::queue_status_t  qs
);

  lccs_pkg::job_t                   entries [lccs_pkg::QUEUE_DEPTH];
  logic [lccs_pkg::QPTR_W-1:0]      wr_ptr;
  logic [lccs_pkg::QPTR_W-1:0]      rd_ptr;
  logic [lccs_pkg::QFILL_W-1:0]     fill;

  assign qs.full  = (fill == lccs_pkg::QFILL_W'(lccs_pkg::QUEUE_DEPTH));
  assign qs.empty = (fill == '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_job;
        wr_ptr <= (wr_ptr == lccs_pkg::QPTR_W'(lccs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lccs_pkg::QPTR_W'(lccs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ sv/lccs_back.sv @@
// ----------------------------------------------------------------------------
// lccs_back
// executes jobs: cost table, load counters and the least cost scan
// ----------------------------------------------------------------------------
module lccs_back (
  input  logic                     clk,
  input  logic                     rst,
  input  lccs_pkg::cfg_t           cfg,
  input  lccs_pkg::job_t           head,
  input  lccs_pkg::queue_status_t  qs,
  output logic                     pop,
  output logic                     done,
  output lccs_pkg::out_item_t      response
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;

  logic [lccs_pkg::COST_BITS-1:0] cost_mem [lccs_pkg::SERVERS * lccs_pkg::SERVERS];
  logic [lccs_pkg::SERVERS * lccs_pkg::SERVERS-1:0] cost_valid;
  logic [lccs_pkg::COST_BITS-1:0] rd_cost;
  logic                           rd_valid;
  logic [lccs_pkg::ADDR_W-1:0]    rd_addr;
  logic [lccs_pkg::ADDR_W-1:0]    wr_addr;
  logic                           mem_we;

  logic [lccs_pkg::LOAD_BITS-1:0] load_count [lccs_pkg::SERVERS];
  logic [lccs_pkg::IDX_W-1:0]     load_addr;
  logic [lccs_pkg::LOAD_BITS-1:0] load_rd;

  logic [lccs_pkg::IDX_W-1:0]     scan_srv;
  logic [lccs_pkg::COUNT_W-1:0]   issue_idx;
  logic                           issue_now;
  logic                           pend;
  logic [lccs_pkg::IDX_W-1:0]     pidx;
  logic                           found;
  logic [lccs_pkg::IDX_W-1:0]     best;
  logic [lccs_pkg::COST_BITS-1:0] best_cost;
  logic [lccs_pkg::LOAD_BITS-1:0] best_load;
  logic [lccs_pkg::COST_BITS-1:0] eval_cost;
  logic                           skip;
  logic                           take;
  logic                           done_next;

  assign pop       = (state == S_IDLE) && !qs.empty;
  assign mem_we    = pop && (head.op == lccs_pkg::OP_WRITE);
  assign wr_addr   = {head.server, head.target};
  assign rd_addr   = {scan_srv, issue_idx[lccs_pkg::IDX_W-1:0]};
  assign issue_now = (issue_idx < cfg.count);
  assign load_addr = (state == S_IDLE) ? head.server : pidx;
  assign load_rd   = load_count[load_addr];

  // compare stage on the registered cost read
  always_comb begin
    eval_cost = rd_valid ? rd_cost : lccs_pkg::NO_LINK;
    skip = (pidx == scan_srv) || (eval_cost == lccs_pkg::NO_LINK) ||
           (load_rd >= cfg.load_limit) || (load_rd == lccs_pkg::LOAD_MAX);
    take = !skip && (!found || (eval_cost < best_cost) ||
           ((eval_cost == best_cost) && (load_rd < best_load)));
  end

  // result strobe: write, complete and out-of-range distribute jobs leaving the queue, or the end of a scan
  always_comb begin
    case (state)
      S_IDLE: begin
        done_next = !qs.empty && ((head.op == lccs_pkg::OP_WRITE) ||
                    (head.op == lccs_pkg::OP_COMPLETE) ||
                    ((head.op == lccs_pkg::OP_DISTRIBUTE) && !head.in_range));
      end
      S_SCAN: begin
        done_next = !issue_now && !pend;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // cost table storage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cost_mem[wr_addr] <= head.cost;
    end
    rd_cost <= cost_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      pend       <= 1'b0;
      found      <= 1'b0;
      cost_valid <= '0;
      for (int i = 0; i < lccs_pkg::SERVERS; i++) begin
        load_count[i] <= '0;
      end
    end else begin
      done     <= done_next;
      rd_valid <= cost_valid[rd_addr];
      case (state)
        S_IDLE: begin
          if (!qs.empty) begin
            case (head.op)
              lccs_pkg::OP_WRITE: begin
                cost_valid[wr_addr] <= 1'b1;
                response <= '{lccs_pkg::ST_WRITTEN, 4'd0, 16'd0};
              end
              lccs_pkg::OP_COMPLETE: begin
                if (!head.in_range || (load_rd == '0)) begin
                  response <= '{lccs_pkg::ST_COMP_ERR, head.server, 16'd0};
                end else begin
                  load_count[head.server] <= load_rd - 1'b1;
                  response <= '{lccs_pkg::ST_COMPLETED, head.server, load_rd - 1'b1};
                end
              end
              lccs_pkg::OP_DISTRIBUTE: begin
                if (!head.in_range) begin
                  response <= '{lccs_pkg::ST_NONE, 4'd0, 16'd0};
                end else begin
                  state     <= S_SCAN;
                  scan_srv  <= head.server;
                  issue_idx <= '0;
                  pend      <= 1'b0;
                  found     <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          pend <= issue_now;
          pidx <= issue_idx[lccs_pkg::IDX_W-1:0];
          if (issue_now) begin
            issue_idx <= issue_idx + 1'b1;
          end
          if (pend && take) begin
            found     <= 1'b1;
            best      <= pidx;
            best_cost <= eval_cost;
            best_load <= load_rd;
          end
          if (!issue_now && !pend) begin
            state <= S_IDLE;
            if (found) begin
              load_count[best] <= best_load + 1'b1;
              response <= '{lccs_pkg::ST_ASSIGNED, best, best_load + 1'b1};
            end else begin
              response <= '{lccs_pkg::ST_NONE, 4'd0, 16'd0};
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/least_cost_capacity_server_selector.sv @@
// ----------------------------------------------------------------------------
// least_cost_capacity_server_selector
// picks the cheapest linked server below its load limit and tracks loads
// ----------------------------------------------------------------------------
// a command transaction is taken at a clock edge with start high and busy low;
// each command gives one result, shown on response for a single cycle with
// done high, and the receiver cannot stall it, so results must be taken as
// they come. accepted commands go into a two-entry queue; busy is high while
// that queue is full. write and complete commands are carried out, and their
// result registered, as they leave the queue. a distribute reads one cost
// entry per cycle from the cost table, so its result comes at the end of a
// scan over min(servers_in_use, 16) entries; a distribute whose start server
// is out of use answers as it leaves the queue. the cost table reads as no
// link after reset through one valid bit per entry, so there is no clearing
// pass. unused command code 3 is accepted and dropped without a result.
// configuration must be written only while the block is idle; the block
// itself does not enforce this.
module least_cost_capacity_server_selector (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  lccs_pkg::in_item_t   request,
  output logic                 busy,
  output logic                 done,
  output lccs_pkg::out_item_t  response,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);

  // configuration registers
  logic [4:0]                     servers_in_use;
  logic [lccs_pkg::LOAD_BITS-1:0] load_limit;
  lccs_pkg::cfg_t                 cfg;

  // queue connections
  logic                     push;
  logic                     pop;
  lccs_pkg::job_t           push_job;
  lccs_pkg::job_t           head;
  lccs_pkg::queue_status_t  qs;

  always_ff @(posedge clk) begin
    if (rst) begin
      servers_in_use <= 5'd16;
      load_limit     <= 16'hffff;
    end else if (cfg_write) begin
      case (cfg_index)
        lccs_pkg::REG_SERVERS_IN_USE: servers_in_use <= cfg_data[4:0];
        lccs_pkg::REG_LOAD_LIMIT:     load_limit     <= cfg_data;
        default: ;
      endcase
    end
  end

  // servers taking part, capped at the table size
  always_comb begin
    cfg.load_limit = load_limit;
    if ({1'b0, servers_in_use} > 6'(lccs_pkg::SERVERS)) begin
      cfg.count = lccs_pkg::COUNT_W'(lccs_pkg::SERVERS);
    end else begin
      cfg.count = lccs_pkg::COUNT_W'(servers_in_use);
    end
  end

  // front: accept and classify each transaction
  lccs_front u_front (
    .start   (start),
    .request (request),
    .cfg     (cfg),
    .qs      (qs),
    .busy    (busy),
    .push    (push),
    .job     (push_job)
  );

  // job queue decouples acceptance from execution
  lccs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qs       (qs)
  );

  // back: cost table, load counters and the scan
  lccs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .qs       (qs),
    .pop      (pop),
    .done     (done),
    .response (response)
  );

endmodule
